@@ design/qlt_pkg.sv @@
`timescale 1ns / 1ps

package qlt_pkg;

    // Longest string whose bytes are tokenized; later bytes only raise overflow.
    localparam longint MAX_STRING_BYTES = 65536;
    // Positions run up to and including MAX_STRING_BYTES.
    localparam int POS_W = $clog2(MAX_STRING_BYTES + 1);
    localparam int OUT_W = 16;
    localparam int CHAR_W = 8;
    localparam int CMD_W = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_LIMIT = POS_W'(MAX_STRING_BYTES);
    localparam t_pos OUT_MAX = POS_W'((64'd1 << OUT_W) - 64'd1);

    // Input commands; the unused code behaves as CMD_END.
    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LAST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM = 1'b1;

    localparam logic [CHAR_W-1:0] QUOTE_BYTE = 8'h22;
    localparam logic [CHAR_W-1:0] SPACE_BYTE = 8'h20;
    localparam logic [CHAR_W-1:0] TAB_BYTE = 8'h09;
    localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'd44;

    typedef struct packed {
        logic [OUT_W-1:0] token_offset;
        logic [OUT_W-1:0] token_length;
        logic             list_done;
        logic             overflow;
    } t_result;

    function automatic logic [OUT_W-1:0] sat_out(input t_pos v);
        sat_out = (v > OUT_MAX) ? {OUT_W{1'b1}} : OUT_W'(v);
    endfunction

    // Token length from start and content end, less the closing quote in trim mode.
    function automatic t_pos token_len(input t_pos cend, input t_pos tstart,
                                       input logic lwq, input logic trim);
        t_pos len;
        len = (cend >= tstart) ? t_pos'(cend - tstart) : '0;
        if (trim && lwq && (len != '0)) begin
            len = t_pos'(len - t_pos'(1));
        end
        token_len = len;
    endfunction

endpackage

@@ design/qlt_if.sv @@
`timescale 1ns / 1ps

interface qlt_in_if;
    logic                          valid;
    logic                          ready;
    logic [qlt_pkg::CMD_W-1:0]     cmd;
    logic [qlt_pkg::CHAR_W-1:0]    char_in;

    modport source(output valid, output cmd, output char_in, input ready);
    modport sink(input valid, input cmd, input char_in, output ready);
endinterface

interface qlt_out_if;
    logic                          valid;
    logic                          ready;
    logic [qlt_pkg::OUT_W-1:0]     token_offset;
    logic [qlt_pkg::OUT_W-1:0]     token_length;
    logic                          list_done;
    logic                          overflow;

    modport source(output valid, output token_offset, output token_length,
                   output list_done, output overflow, input ready);
    modport sink(input valid, input token_offset, input token_length,
                 input list_done, input overflow, output ready);
endinterface

@@ design/quoted_list_tokenizer.sv @@
`timescale 1ns / 1ps

// Quoted list tokenizer.
// The input channel carries one beat per string byte: cmd says whether the
// byte is an inner byte, the final byte of the string, or a bare end of string.
// The output channel carries one beat per token: its offset and trimmed length,
// a list_done flag on the last token of the string, and the sticky overflow flag.
// The separator byte and the quote trim mode are written through the plain
// configuration port; the user must write them only while the block is idle,
// as the block itself does not enforce it. A beat accepted into the input
// register is processed once the result buffer has room; its tokens are then
// registered into the result buffer, from which they are offered on the output.
// Throughput is one input beat per cycle while the receiver takes every token;
// the only exception is a final byte that is a separator, which yields two
// tokens and fills the two-entry result buffer.
// When the receiver stalls, results wait in the buffer, the input register
// fills, and ready drops only once both are occupied.
// Reset clears the string state, empties both registers and restores the
// separator to comma with quote trimming off.
module quoted_list_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qlt_in_if.sink                          i_in,
    qlt_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [qlt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qlt_pkg::CHAR_W-1:0]      i_cfg_data
);
    import qlt_pkg::*;

    // Configuration registers.
    logic [CHAR_W-1:0] r_sep;
    logic              r_trim;

    // Input register.
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [CHAR_W-1:0] r_char;

    // String state.
    t_pos r_pos, n_pos;
    t_pos r_tstart, n_tstart;
    t_pos r_cend, n_cend;
    t_pos r_field, n_field;
    logic r_inside, n_inside;
    logic r_qopen, n_qopen;
    logic r_lwq, n_lwq;
    logic r_after, n_after;
    logic r_any, n_any;
    logic r_ovf, n_ovf;

    // Two-entry result buffer; entry 0 is the head.
    t_result    r_res [2];
    t_result    n_res [2];
    logic [1:0] r_cnt, n_cnt;

    logic    pop;
    logic    process;
    logic    ra_v, rb_v;
    t_result ra, rb;

    assign pop = o_out.valid && o_out.ready;
    // The buffer must have room for two tokens once this cycle's pop is done.
    assign process = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign i_in.ready = !r_in_valid || process;

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.token_offset = r_res[0].token_offset;
    assign o_out.token_length = r_res[0].token_length;
    assign o_out.list_done    = r_res[0].list_done;
    assign o_out.overflow     = r_res[0].overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep  <= SEPARATOR_RESET;
            r_trim <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEPARATOR: r_sep <= i_cfg_data;
                CFG_TRIM:      r_trim <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd  <= i_in.cmd;
            r_char <= i_in.char_in;
        end
    end

    // Byte step followed by the end-of-string step, both on the held beat.
    always_comb begin : proc_step
        t_pos pos1;
        logic is_space;
        logic is_sep;
        logic is_quote;
        logic byte_cmd;
        logic end_cmd;

        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_cend   = r_cend;
        n_field  = r_field;
        n_inside = r_inside;
        n_qopen  = r_qopen;
        n_lwq    = r_lwq;
        n_after  = r_after;
        n_any    = r_any;
        n_ovf    = r_ovf;
        ra_v     = 1'b0;
        rb_v     = 1'b0;
        ra       = '0;
        rb       = '0;

        pos1     = t_pos'(r_pos + t_pos'(1));
        is_space = (r_char == SPACE_BYTE) || (r_char == TAB_BYTE);
        is_sep   = (r_char == r_sep);
        is_quote = (r_char == QUOTE_BYTE);
        byte_cmd = r_cmd inside {CMD_BYTE, CMD_LAST};
        end_cmd  = (r_cmd != CMD_BYTE);

        if (process && byte_cmd) begin
            if (r_pos >= POS_LIMIT) begin
                n_ovf = 1'b1;
            end else begin
                n_pos = pos1;
                if (!r_inside) begin
                    if (is_space) begin
                        // Leading whitespace is skipped.
                    end else if (is_sep) begin
                        ra_v = 1'b1;
                        ra.token_offset = sat_out(r_field);
                        ra.token_length = '0;
                        ra.overflow = r_ovf;
                        n_any   = 1'b1;
                        n_field = pos1;
                        n_after = 1'b1;
                    end else begin
                        n_inside = 1'b1;
                        n_cend   = pos1;
                        if (is_quote) begin
                            n_qopen  = 1'b1;
                            n_tstart = r_trim ? pos1 : r_pos;
                            n_lwq    = !r_trim;
                        end else begin
                            n_qopen  = 1'b0;
                            n_tstart = r_pos;
                            n_lwq    = 1'b0;
                        end
                    end
                end else if (is_sep && !r_qopen) begin
                    ra_v = 1'b1;
                    ra.token_offset = sat_out(r_tstart);
                    ra.token_length = sat_out(token_len(r_cend, r_tstart, r_lwq, r_trim));
                    ra.overflow = r_ovf;
                    n_any    = 1'b1;
                    n_field  = pos1;
                    n_after  = 1'b1;
                    n_inside = 1'b0;
                end else begin
                    if (is_quote) begin
                        n_qopen = !r_qopen;
                    end
                    if (!is_space) begin
                        n_cend = pos1;
                        n_lwq  = is_quote;
                    end
                end
            end
        end

        if (process && end_cmd) begin
            if (n_inside) begin
                rb_v = 1'b1;
                rb.token_offset = sat_out(n_tstart);
                rb.token_length = sat_out(token_len(n_cend, n_tstart, n_lwq, r_trim));
                rb.overflow = n_ovf;
            end else if (n_after || !n_any) begin
                // Trailing separator, or a string without any token.
                rb_v = 1'b1;
                rb.token_offset = sat_out(n_field);
                rb.token_length = '0;
                rb.overflow = n_ovf;
            end
            if (rb_v) begin
                rb.list_done = 1'b1;
            end else begin
                ra.list_done = 1'b1;
            end
            n_pos    = '0;
            n_tstart = '0;
            n_cend   = '0;
            n_field  = '0;
            n_inside = 1'b0;
            n_qopen  = 1'b0;
            n_lwq    = 1'b0;
            n_after  = 1'b0;
            n_any    = 1'b0;
            n_ovf    = 1'b0;
        end
    end

    // Result buffer: the head leaves on a pop; a processed beat always finds
    // the buffer empty after that pop, so its tokens land from entry 0 up.
    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        if (pop) begin
            n_res[0] = r_res[1];
            n_cnt    = r_cnt - 2'd1;
        end
        if (ra_v && rb_v) begin
            n_res[0] = ra;
            n_res[1] = rb;
            n_cnt    = 2'd2;
        end else if (ra_v) begin
            n_res[0] = ra;
            n_cnt    = 2'd1;
        end else if (rb_v) begin
            n_res[0] = rb;
            n_cnt    = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_pos    <= '0;
            r_tstart <= '0;
            r_cend   <= '0;
            r_field  <= '0;
            r_inside <= 1'b0;
            r_qopen  <= 1'b0;
            r_lwq    <= 1'b0;
            r_after  <= 1'b0;
            r_any    <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_cend   <= n_cend;
            r_field  <= n_field;
            r_inside <= n_inside;
            r_qopen  <= n_qopen;
            r_lwq    <= n_lwq;
            r_after  <= n_after;
            r_any    <= n_any;
            r_ovf    <= n_ovf;
        end
    end

    // The result buffer never holds more than its two entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    // The byte position stops at the string limit.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("byte position beyond string limit");

    // An end of string leaves the tokenizer at the start of a fresh string.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && (r_cmd != CMD_BYTE)) |=> ((r_pos == '0) && !r_inside && !r_ovf))
        else $error("string state not cleared after end of string");

    // A processed beat that ends a string always produces at least one token.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && (r_cmd != CMD_BYTE)) |-> (ra_v || rb_v))
        else $error("end of string without a token");

endmodule
